// ===== rtl/rgba_moving_average_assert.svh =====
// Assertion macros shared by the rgba_moving_average RTL.
// Expects clk and rst in scope at the point of use; no other dependencies.
`ifndef RGBA_MOVING_AVERAGE_ASSERT_SVH
`define RGBA_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication.
`define RGBMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RGBMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rgbma_pkg.sv =====
// Shared types and constants for the rgba_moving_average block.
// No dependencies.
package rgbma_pkg;

  localparam int DEFAULT_WINDOW = 8;
  localparam int CHAN_W         = 8;
  localparam int NUM_CHAN       = 4;
  localparam int WORD_W         = CHAN_W * NUM_CHAN;
  localparam int QUOT_W         = CHAN_W;
  localparam int STEP_W         = $clog2(QUOT_W);

  typedef struct packed {
    logic capture;   // latch input item, read oldest ring entry
    logic update;    // update running sums, write ring, advance pointers
    logic div_load;  // seed the dividers
    logic div_step;  // one quotient bit per channel
    logic load_out;  // move quotients into the output register
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

// ===== rtl/rgbma_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module rgbma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rgbma_dp.sv =====
// Datapath: sample ring, running channel sums, serial dividers, output register.
// Depends on rgbma_pkg, rgbma_ram and rgba_moving_average_assert.svh.
`include "rgba_moving_average_assert.svh"

module rgbma_dp import rgbma_pkg::*; #(
  parameter int WINDOW = DEFAULT_WINDOW
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [CHAN_W-1:0] red_in,
  input  logic [CHAN_W-1:0] green_in,
  input  logic [CHAN_W-1:0] blue_in,
  input  logic [CHAN_W-1:0] alpha_in,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [CHAN_W-1:0] red_avg,
  output logic [CHAN_W-1:0] green_avg,
  output logic [CHAN_W-1:0] blue_avg,
  output logic [CHAN_W-1:0] alpha_avg
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = CHAN_W + CNT_W;

  logic [CHAN_W-1:0] din      [NUM_CHAN];
  logic [CHAN_W-1:0] sample   [NUM_CHAN];
  logic [CHAN_W-1:0] old      [NUM_CHAN];
  logic [SUM_W-1:0]  sum      [NUM_CHAN];
  logic [SUM_W-1:0]  sum_next [NUM_CHAN];
  logic [CNT_W-1:0]  rem      [NUM_CHAN];
  logic [CNT_W-1:0]  rem_next [NUM_CHAN];
  logic [QUOT_W-1:0] shq      [NUM_CHAN];
  logic [QUOT_W-1:0] shq_next [NUM_CHAN];
  logic [CNT_W:0]    trial    [NUM_CHAN];
  logic [CHAN_W-1:0] avg      [NUM_CHAN];

  logic [PTR_W-1:0]  write_pos;
  logic [CNT_W-1:0]  fill;
  logic              full;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;

  assign din[0] = red_in;
  assign din[1] = green_in;
  assign din[2] = blue_in;
  assign din[3] = alpha_in;

  assign full  = (fill == CNT_W'(WINDOW));
  assign wdata = {sample[3], sample[2], sample[1], sample[0]};

  rgbma_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (write_pos),
    .wdata (wdata),
    .re    (cmd.capture),
    .raddr (write_pos),
    .rdata (rdata)
  );

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      old[c]      = rdata[c*CHAN_W +: CHAN_W];
      sum_next[c] = sum[c] + SUM_W'(sample[c]) - (full ? SUM_W'(old[c]) : '0);
      trial[c]    = {rem[c], shq[c][QUOT_W-1]};
      if (trial[c] >= {1'b0, fill}) begin
        rem_next[c] = CNT_W'(trial[c] - {1'b0, fill});
        shq_next[c] = {shq[c][QUOT_W-2:0], 1'b1};
      end else begin
        rem_next[c] = trial[c][CNT_W-1:0];
        shq_next[c] = {shq[c][QUOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        sum[c] <= '0;
      end
    end else begin
      if (cmd.update) begin
        write_pos <= (write_pos == PTR_W'(WINDOW - 1)) ? '0 : write_pos + 1'b1;
        if (!full) begin
          fill <= fill + 1'b1;
        end
        for (int c = 0; c < NUM_CHAN; c++) begin
          sum[c] <= sum_next[c];
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (cmd.capture) begin
        sample[c] <= din[c];
      end
      if (cmd.div_load) begin
        rem[c] <= sum[c][SUM_W-1:CHAN_W];
        shq[c] <= sum[c][CHAN_W-1:0];
      end else if (cmd.div_step) begin
        rem[c] <= rem_next[c];
        shq[c] <= shq_next[c];
      end
      if (cmd.load_out) begin
        avg[c] <= shq[c];
      end
    end
  end

  assign status.out_valid = out_valid;

  assign red_avg   = avg[0];
  assign green_avg = avg[1];
  assign blue_avg  = avg[2];
  assign alpha_avg = avg[3];

  `RGBMA_ASSERT_NEXT(a_fill_step, cmd.update && !full, fill == $past(fill) + 1'b1, "fill count did not advance")
  `RGBMA_ASSERT_NOW(a_out_rise, $rose(out_valid), $past(cmd.load_out), "result appeared without a load")
  `RGBMA_ASSERT_NOW(a_no_overwrite, cmd.load_out, !(out_valid && out_stall), "pending result overwritten")

endmodule

// ===== rtl/rgbma_ctrl.sv =====
// Controller: sequences capture, sum update, serial divide and result hand-off.
// Depends on rgbma_pkg.
module rgbma_ctrl import rgbma_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step;
  logic              out_free;

  assign out_free = !status.out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == STEP_W'(QUOT_W - 1)) begin
          state_next = S_WR;
        end
      end
      S_WR: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
    end
  end

endmodule

// ===== rtl/rgba_moving_average.sv =====
// Four-channel byte mean over a sliding window of the last WINDOW items.
// Top level of the block; ties controller and datapath together.
// Depends on rgbma_pkg, rgbma_ctrl and rgbma_dp.
//
// Input channel: in_valid / in_stall with red_in, green_in, blue_in, alpha_in.
// Output channel: out_valid / out_stall with red_avg .. alpha_avg.
// An item moves on a rising edge where valid is high and stall is low.
// Each input item yields exactly one result: the truncated mean of every
// item held in the window, fewer than WINDOW while the window fills up.
// The block keeps running channel sums (new sample in, evicted sample out),
// then divides by the fill count one quotient bit per cycle, all four
// channels in parallel.
// The block takes no new item until the last one has passed ring read/update
// and the 8-step serial divider and its result has moved to the output register.
// The result sits in an output register; a new item is taken while it waits.
// If out_stall holds the result and a second result is ready, the block
// holds that one internally and stalls the input until the register frees.
// Synchronous reset empties the window (fill count and sums to zero) and
// drops any pending result; ring contents are not cleared.
module rgba_moving_average import rgbma_pkg::*; #(
  parameter int WINDOW = DEFAULT_WINDOW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] red_in,
  input  logic [CHAN_W-1:0] green_in,
  input  logic [CHAN_W-1:0] blue_in,
  input  logic [CHAN_W-1:0] alpha_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] red_avg,
  output logic [CHAN_W-1:0] green_avg,
  output logic [CHAN_W-1:0] blue_avg,
  output logic [CHAN_W-1:0] alpha_avg
);

  cmd_t    cmd;
  status_t status;

  rgbma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rgbma_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .red_avg   (red_avg),
    .green_avg (green_avg),
    .blue_avg  (blue_avg),
    .alpha_avg (alpha_avg)
  );

endmodule
